// ===== hw/rtl/assert_macros.svh =====
// Assertion helpers shared by the divider, root and top-level RTL files of the rotated basis block.
// Both expect the clock aclk in scope; SVI_ASSERT also expects the active-low reset aresetn.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define SVI_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Check a property on every clock edge, reset included.
`define SVI_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hw/rtl/svi_rb_pkg.sv =====
// ----------------------------------------------------------------------------
// svi_rb_pkg
// Shared types and constants of the rotated basis pipeline.
// ----------------------------------------------------------------------------
package svi_rb_pkg;

    // Default word format: Q8.24 in 32 bits
    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 24;

    // 1/sqrt2 as unsigned Q0.32
    localparam int          CONST_FRAC    = 32;
    localparam logic [31:0] INV_SQRT2_Q32 = 32'd3037000500;

    // Configuration register indexes
    typedef enum logic [0:0] {
        CFG_CENTRE_SHIFT = 1'b0,
        CFG_WIDTH_SCALE  = 1'b1
    } svi_rb_cfg_idx_t;

    // Control that travels beside the data in every stage
    typedef struct packed {
        logic valid;
        logic last;
        logic sat;
    } svi_rb_ctl_t;

endpackage

// ===== hw/rtl/svi_rb_div.sv =====
// ----------------------------------------------------------------------------
// svi_rb_div
// Forms y = (k - centre)/width: one quotient bit per stage, rounded and clipped.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svi_rb_div import svi_rb_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  svi_rb_ctl_t  in_ctl,
    input  logic [W-1:0] log_strike,
    input  logic [W-1:0] centre_shift,
    input  logic [W-2:0] width_scale,
    output svi_rb_ctl_t  out_ctl,
    output logic [W-1:0] ymag,
    output logic         yneg
);
    localparam int NW = W + F + 2;              // rounded dividend
    localparam int QW = W + 1;                  // quotient bits worked out
    localparam int TW = NW - QW;                // dividend bits above them
    localparam int CW = (TW > W - 1) ? TW : W - 1;
    localparam logic [W-1:0] Y_POS_LIM = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] Y_NEG_LIM = Y_POS_LIM + W'(1);

    // Stage 0: exact difference and its magnitude
    logic [W:0]   diff;
    svi_rb_ctl_t  s0_ctl_reg;
    logic         s0_neg_reg;
    logic [W:0]   s0_mag_reg;

    assign diff = {log_strike[W-1], log_strike} - {centre_shift[W-1], centre_shift};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_ctl_reg <= '0;
        end else if (adv) begin
            s0_ctl_reg <= in_ctl;
        end
        if (adv) begin
            s0_neg_reg <= diff[W];
            s0_mag_reg <= diff[W] ? (~diff + (W+1)'(1)) : diff;
        end
    end

    // Stage 1: add the rounding term, catch quotients past QW bits
    logic [NW-1:0] num;
    logic [TW-1:0] top;
    logic          ovf;
    logic          sig_zero;
    logic          mag_zero;

    svi_rb_ctl_t   dv_ctl_reg  [QW+1];
    logic [W-2:0]  dv_rem_reg  [QW+1];
    logic [QW-1:0] dv_num_reg  [QW+1];
    logic [QW-1:0] dv_q_reg    [QW+1];
    logic          dv_neg_reg  [QW+1];
    logic          dv_ovf_reg  [QW+1];
    logic          dv_zero_reg [QW+1];

    assign num      = {1'b0, s0_mag_reg, {F{1'b0}}} + NW'(width_scale >> 1);
    assign top      = num[NW-1:QW];
    assign ovf      = CW'(top) >= CW'(width_scale);
    assign sig_zero = (width_scale == '0);
    assign mag_zero = (s0_mag_reg == '0);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_ctl_reg[0] <= '0;
        end else if (adv) begin
            dv_ctl_reg[0] <= s0_ctl_reg;
        end
        if (adv) begin
            dv_rem_reg[0]  <= (W-1)'(top);
            dv_num_reg[0]  <= num[QW-1:0];
            dv_q_reg[0]    <= '0;
            dv_neg_reg[0]  <= s0_neg_reg;
            dv_ovf_reg[0]  <= sig_zero ? !mag_zero : ovf;
            dv_zero_reg[0] <= sig_zero && mag_zero;
        end
    end

    // Restoring division: one quotient bit per stage
    for (genvar i = 0; i < QW; i++) begin : g_div
        logic [W-1:0] rem_w;
        logic         ge;
        logic [W-1:0] rem_next;

        assign rem_w    = {dv_rem_reg[i], dv_num_reg[i][QW-1]};
        assign ge       = rem_w >= {1'b0, width_scale};
        assign rem_next = ge ? (rem_w - {1'b0, width_scale}) : rem_w;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_ctl_reg[i+1] <= '0;
            end else if (adv) begin
                dv_ctl_reg[i+1] <= dv_ctl_reg[i];
            end
            if (adv) begin
                dv_rem_reg[i+1]  <= rem_next[W-2:0];
                dv_num_reg[i+1]  <= {dv_num_reg[i][QW-2:0], 1'b0};
                dv_q_reg[i+1]    <= {dv_q_reg[i][QW-2:0], ge};
                dv_neg_reg[i+1]  <= dv_neg_reg[i];
                dv_ovf_reg[i+1]  <= dv_ovf_reg[i];
                dv_zero_reg[i+1] <= dv_zero_reg[i];
            end
        end
    end

    // Clip stage: limit to the signed word range
    logic [W-1:0] lim;
    logic         clip;
    svi_rb_ctl_t  cl_ctl_next;
    svi_rb_ctl_t  cl_ctl_reg;
    logic [W-1:0] cl_ymag_next;
    logic [W-1:0] cl_ymag_reg;
    logic         cl_neg_reg;

    assign lim  = dv_neg_reg[QW] ? Y_NEG_LIM : Y_POS_LIM;
    assign clip = !dv_zero_reg[QW] && (dv_ovf_reg[QW] || (dv_q_reg[QW] > {1'b0, lim}));

    always_comb begin
        cl_ctl_next     = dv_ctl_reg[QW];
        cl_ctl_next.sat = clip;
        if (dv_zero_reg[QW]) begin
            cl_ymag_next = '0;
        end else if (clip) begin
            cl_ymag_next = lim;
        end else begin
            cl_ymag_next = dv_q_reg[QW][W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cl_ctl_reg <= '0;
        end else if (adv) begin
            cl_ctl_reg <= cl_ctl_next;
        end
        if (adv) begin
            cl_ymag_reg <= cl_ymag_next;
            cl_neg_reg  <= dv_neg_reg[QW];
        end
    end

    assign out_ctl = cl_ctl_reg;
    assign ymag    = cl_ymag_reg;
    assign yneg    = cl_neg_reg;

    `SVI_ASSERT(a_ymag_range, cl_ctl_reg.valid |-> (cl_ymag_reg <= Y_NEG_LIM) && (cl_neg_reg || (cl_ymag_reg <= Y_POS_LIM)), "y magnitude out of range")

endmodule

// ===== hw/rtl/svi_rb_sqrt.sv =====
// ----------------------------------------------------------------------------
// svi_rb_sqrt
// Forms z = sqrt(y*y + 1): squarer, then one root bit per stage, rounded.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svi_rb_sqrt import svi_rb_pkg::*; #(
    parameter int W = DATA_WIDTH_DEF,
    parameter int F = FRAC_BITS_DEF,
    localparam int XW = (2 * W > 2 * F + 1) ? 2 * W : 2 * F + 2,
    localparam int RW = XW / 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         adv,
    input  svi_rb_ctl_t  in_ctl,
    input  logic [W-1:0] ymag,
    input  logic         yneg,
    output svi_rb_ctl_t  out_ctl,
    output logic [RW:0]  z,
    output logic [W-1:0] ymag_o,
    output logic         yneg_o
);
    localparam logic [RW:0] Z_ONE = (RW+1)'(1) << F;

    // Stage A: square
    svi_rb_ctl_t    a_ctl_reg;
    logic [2*W-1:0] a_sq_reg;
    logic [W-1:0]   a_ymag_reg;
    logic           a_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_ctl_reg <= '0;
        end else if (adv) begin
            a_ctl_reg <= in_ctl;
        end
        if (adv) begin
            a_sq_reg   <= (2*W)'(ymag) * (2*W)'(ymag);
            a_ymag_reg <= ymag;
            a_neg_reg  <= yneg;
        end
    end

    // Stage B: add one, then the root stages
    svi_rb_ctl_t   rt_ctl_reg  [RW+1];
    logic [XW-1:0] rt_x_reg    [RW+1];
    logic [RW+1:0] rt_rem_reg  [RW+1];
    logic [RW-1:0] rt_root_reg [RW+1];
    logic [W-1:0]  rt_ymag_reg [RW+1];
    logic          rt_neg_reg  [RW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rt_ctl_reg[0] <= '0;
        end else if (adv) begin
            rt_ctl_reg[0] <= a_ctl_reg;
        end
        if (adv) begin
            rt_x_reg[0]    <= XW'(a_sq_reg) + (XW'(1) << (2 * F));
            rt_rem_reg[0]  <= '0;
            rt_root_reg[0] <= '0;
            rt_ymag_reg[0] <= a_ymag_reg;
            rt_neg_reg[0]  <= a_neg_reg;
        end
    end

    // Digit-by-digit root: two radicand bits per stage
    for (genvar j = 0; j < RW; j++) begin : g_root
        logic [RW+3:0] rem_t;
        logic [RW+3:0] trial;
        logic          ge;
        logic [RW+3:0] rem_next;

        assign rem_t    = {rt_rem_reg[j], rt_x_reg[j][XW-1 -: 2]};
        assign trial    = (RW+4)'({rt_root_reg[j], 2'b01});
        assign ge       = rem_t >= trial;
        assign rem_next = ge ? (rem_t - trial) : rem_t;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rt_ctl_reg[j+1] <= '0;
            end else if (adv) begin
                rt_ctl_reg[j+1] <= rt_ctl_reg[j];
            end
            if (adv) begin
                rt_x_reg[j+1]    <= {rt_x_reg[j][XW-3:0], 2'b00};
                rt_rem_reg[j+1]  <= (RW+2)'(rem_next);
                rt_root_reg[j+1] <= (RW)'({rt_root_reg[j], ge});
                rt_ymag_reg[j+1] <= rt_ymag_reg[j];
                rt_neg_reg[j+1]  <= rt_neg_reg[j];
            end
        end
    end

    // Round to nearest: bump when the remainder exceeds the root
    svi_rb_ctl_t  rd_ctl_reg;
    logic [RW:0]  rd_z_reg;
    logic [W-1:0] rd_ymag_reg;
    logic         rd_neg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ctl_reg <= '0;
        end else if (adv) begin
            rd_ctl_reg <= rt_ctl_reg[RW];
        end
        if (adv) begin
            rd_z_reg    <= (RW+1)'(rt_root_reg[RW])
                         + (RW+1)'(rt_rem_reg[RW] > (RW+2)'(rt_root_reg[RW]));
            rd_ymag_reg <= rt_ymag_reg[RW];
            rd_neg_reg  <= rt_neg_reg[RW];
        end
    end

    assign out_ctl = rd_ctl_reg;
    assign z       = rd_z_reg;
    assign ymag_o  = rd_ymag_reg;
    assign yneg_o  = rd_neg_reg;

    `SVI_ASSERT(a_z_at_least_one, rd_ctl_reg.valid |-> rd_z_reg >= Z_ONE, "root below one")

endmodule

// ===== hw/rtl/svi_rb_scale.sv =====
// ----------------------------------------------------------------------------
// svi_rb_scale
// Forms z+y and z-y, scales both by 1/sqrt2, rounds and clips to the word.
// ----------------------------------------------------------------------------
module svi_rb_scale import svi_rb_pkg::*; #(
    parameter int W  = DATA_WIDTH_DEF,
    parameter int ZW = DATA_WIDTH_DEF + 1
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          adv,
    input  svi_rb_ctl_t   in_ctl,
    input  logic [ZW-1:0] z,
    input  logic [W-1:0]  ymag,
    input  logic          yneg,
    output svi_rb_ctl_t   out_ctl,
    output logic [W-2:0]  basis_u,
    output logic [W-2:0]  basis_v
);
    localparam int SW = ((ZW > W) ? ZW : W) + 1;
    localparam int PW = SW + CONST_FRAC;
    localparam int RN = PW - CONST_FRAC + 1;
    localparam logic [RN-1:0] WORD_MAX = RN'({(W-1){1'b1}});

    // Stage 0: rotate
    svi_rb_ctl_t   s0_ctl_reg;
    logic [SW-1:0] s0_su_reg;
    logic [SW-1:0] s0_sv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_ctl_reg <= '0;
        end else if (adv) begin
            s0_ctl_reg <= in_ctl;
        end
        if (adv) begin
            s0_su_reg <= yneg ? (SW'(z) - SW'(ymag)) : (SW'(z) + SW'(ymag));
            s0_sv_reg <= yneg ? (SW'(z) + SW'(ymag)) : (SW'(z) - SW'(ymag));
        end
    end

    // Stage 1: multiply by 1/sqrt2
    svi_rb_ctl_t   s1_ctl_reg;
    logic [PW-1:0] s1_pu_reg;
    logic [PW-1:0] s1_pv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_ctl_reg <= '0;
        end else if (adv) begin
            s1_ctl_reg <= s0_ctl_reg;
        end
        if (adv) begin
            s1_pu_reg <= PW'(s0_su_reg) * PW'(INV_SQRT2_Q32);
            s1_pv_reg <= PW'(s0_sv_reg) * PW'(INV_SQRT2_Q32);
        end
    end

    // Stage 2: round half up, clip, hold for the receiver
    logic [RN-1:0] ru;
    logic [RN-1:0] rv;
    svi_rb_ctl_t   o_ctl_next;
    svi_rb_ctl_t   o_ctl_reg;
    logic [W-2:0]  o_u_reg;
    logic [W-2:0]  o_v_reg;

    assign ru = RN'(s1_pu_reg[PW-1:CONST_FRAC]) + RN'(s1_pu_reg[CONST_FRAC-1]);
    assign rv = RN'(s1_pv_reg[PW-1:CONST_FRAC]) + RN'(s1_pv_reg[CONST_FRAC-1]);

    always_comb begin
        o_ctl_next     = s1_ctl_reg;
        o_ctl_next.sat = s1_ctl_reg.sat || (ru > WORD_MAX) || (rv > WORD_MAX);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            o_ctl_reg <= '0;
        end else if (adv) begin
            o_ctl_reg <= o_ctl_next;
        end
        if (adv) begin
            o_u_reg <= (ru > WORD_MAX) ? WORD_MAX[W-2:0] : ru[W-2:0];
            o_v_reg <= (rv > WORD_MAX) ? WORD_MAX[W-2:0] : rv[W-2:0];
        end
    end

    assign out_ctl = o_ctl_reg;
    assign basis_u = o_u_reg;
    assign basis_v = o_v_reg;

endmodule

// ===== hw/rtl/svi_rotated_basis.sv =====
// Rotated basis pair for quasi-explicit SVI fitting.
// Input stream: one log-moneyness sample k per transaction on s_tdata
// (signed Q8.24), s_tlast marks the last sample of a batch.
// Output stream: one transaction per sample, u = (y+z)/sqrt2 and
// v = (z-y)/sqrt2 on m_tdata, the saturation flag on m_tuser and the
// batch marker on m_tlast, with y = (k - centre)/width, z = sqrt(y*y+1).
// Configuration: cfg_we writes cfg_wdata to the register at cfg_addr
// (0: centre_shift, 1: width_scale); write only while the pipe is empty.
// Throughput: one sample per cycle while the output is not stalled. The
// pipe depth is set by the bit-per-stage divider (W+1 stages) and the
// bit-per-stage square root (W stages when the root width follows the
// data width, as at the default Q8.24 in 32 bits).
// Reset: valid bits clear, centre_shift goes to 0, width_scale to 1.0.
// Stall: while m_tvalid is high and m_tready low, the whole pipe holds and
// s_tready is low; nothing is lost or repeated.
// ----------------------------------------------------------------------------
// svi_rotated_basis
// Top level: configuration registers, stream ports, pipeline enable.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module svi_rotated_basis import svi_rb_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int IN_TW  = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_TW = ((2 * (DATA_WIDTH - 1) + 7) / 8) * 8
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // sample stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TW-1:0]      s_tdata,   // log_strike
    input  logic                  s_tlast,   // batch_end
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_TW-1:0]     m_tdata,   // basis_u, basis_v
    output logic [0:0]            m_tuser,   // saturated
    output logic                  m_tlast,   // batch_end_out
    // configuration
    input  logic                  cfg_we,
    input  svi_rb_cfg_idx_t       cfg_addr,
    input  logic [DATA_WIDTH-1:0] cfg_wdata
);
    localparam int W  = DATA_WIDTH;
    localparam int XW = (2 * W > 2 * FRAC_BITS + 1) ? 2 * W : 2 * FRAC_BITS + 2;
    localparam int RW = XW / 2;
    localparam logic [W-2:0] SIGMA_ONE = (W-1)'(1) << FRAC_BITS;

    // Configuration registers
    logic [W-1:0] centre_reg;
    logic [W-2:0] width_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            centre_reg <= '0;
            width_reg  <= SIGMA_ONE;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_CENTRE_SHIFT: centre_reg <= cfg_wdata;
                CFG_WIDTH_SCALE:  width_reg  <= cfg_wdata[W-2:0];
                default: ;
            endcase
        end
    end

    // Advance the whole pipe unless the output transaction is stalled
    logic        adv;
    svi_rb_ctl_t in_ctl;
    svi_rb_ctl_t div_ctl;
    svi_rb_ctl_t rt_ctl;
    svi_rb_ctl_t out_ctl;

    assign adv      = !out_ctl.valid || m_tready;
    assign s_tready = adv;

    always_comb begin
        in_ctl       = '0;
        in_ctl.valid = s_tvalid;
        in_ctl.last  = s_tlast;
    end

    logic [W-1:0] div_ymag;
    logic         div_neg;
    logic [RW:0]  rt_z;
    logic [W-1:0] rt_ymag;
    logic         rt_neg;
    logic [W-2:0] basis_u;
    logic [W-2:0] basis_v;

    svi_rb_div #(.W(W), .F(FRAC_BITS)) u_div (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .in_ctl       (in_ctl),
        .log_strike   (s_tdata[W-1:0]),
        .centre_shift (centre_reg),
        .width_scale  (width_reg),
        .out_ctl      (div_ctl),
        .ymag         (div_ymag),
        .yneg         (div_neg)
    );

    svi_rb_sqrt #(.W(W), .F(FRAC_BITS)) u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_ctl  (div_ctl),
        .ymag    (div_ymag),
        .yneg    (div_neg),
        .out_ctl (rt_ctl),
        .z       (rt_z),
        .ymag_o  (rt_ymag),
        .yneg_o  (rt_neg)
    );

    svi_rb_scale #(.W(W), .ZW(RW + 1)) u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .in_ctl  (rt_ctl),
        .z       (rt_z),
        .ymag    (rt_ymag),
        .yneg    (rt_neg),
        .out_ctl (out_ctl),
        .basis_u (basis_u),
        .basis_v (basis_v)
    );

    assign m_tvalid = out_ctl.valid;
    assign m_tdata  = OUT_TW'({basis_v, basis_u});
    assign m_tuser  = out_ctl.sat;
    assign m_tlast  = out_ctl.last;

    `SVI_ASSERT_RST(a_reset_clears_out, !aresetn |=> !m_tvalid, "output valid after reset")
    `SVI_ASSERT(a_stall_blocks_input, (m_tvalid && !m_tready) |-> !s_tready, "input taken during stall")

endmodule
